@@ hw/rtl/bfsam_pkg.sv @@
// ---------------------------------------------------------------------------
// bfsam_pkg
// shared types, constants and helpers for the breadth-first search engine
// ---------------------------------------------------------------------------
package bfsam_pkg;

	localparam int MAX_NODES = 16;
	localparam int IDX_W     = $clog2(MAX_NODES);
	localparam int CNT_W     = $clog2(MAX_NODES + 1);
	localparam int KEY_W     = 32;
	localparam int OUT_IDX_W = 6;

	typedef enum logic [1:0] {
		REQ_NODE   = 2'd0,
		REQ_EDGE   = 2'd1,
		REQ_SEARCH = 2'd2,
		REQ_NONE   = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_DUP     = 2'd2,
		ST_UNKNOWN = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		COLOR_WHITE = 2'd0,
		COLOR_GREY  = 2'd1,
		COLOR_BLACK = 2'd2
	} color_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_POP,
		S_SCAN,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic [1:0]              req_type;
		logic signed [KEY_W-1:0] key_a;
		logic signed [KEY_W-1:0] key_b;
	} in_item_t;

	typedef struct packed {
		logic [1:0]              status;
		logic [OUT_IDX_W-1:0]    node_index;
		logic signed [KEY_W-1:0] node_key;
		logic [OUT_IDX_W-1:0]    distance;
		logic [OUT_IDX_W-1:0]    predecessor;
		logic                    has_predecessor;
		logic                    reached;
		logic                    last;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic init;
		logic pop;
		logic scan;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] req_type;
		logic       src_found;
		logic       q_empty;
		logic       scan_done;
		logic       emit_last;
		logic       out_free;
	} stat_t;

	// index of the lowest set bit
	function automatic logic [IDX_W-1:0] lowest_idx(input logic [MAX_NODES-1:0] v);
		logic [IDX_W-1:0] r;
		r = '0;
		for (int i = MAX_NODES - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = IDX_W'(i);
			end
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/bfsam_datapath.sv @@
// ---------------------------------------------------------------------------
// bfsam_datapath
// key table, adjacency matrix, search state, work queue and result register
// ---------------------------------------------------------------------------
module bfsam_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  bfsam_pkg::in_item_t in_data,
	input  bfsam_pkg::cmd_t     cmd,
	output bfsam_pkg::stat_t    stat,
	output logic                out_valid,
	input  logic                out_stall,
	output bfsam_pkg::out_item_t out_data
);
	import bfsam_pkg::*;

	in_item_t                    req_q;
	logic signed [KEY_W-1:0]     key_q    [MAX_NODES];
	logic [MAX_NODES-1:0]        row_q    [MAX_NODES];
	logic [CNT_W-1:0]            count_q;
	color_t                      color_q  [MAX_NODES];
	logic [OUT_IDX_W-1:0]        dist_q   [MAX_NODES];
	logic [IDX_W-1:0]            parent_q [MAX_NODES];
	logic [MAX_NODES-1:0]        pvalid_q;
	logic [IDX_W-1:0]            queue_q  [MAX_NODES];
	logic [IDX_W-1:0]            head_q;
	logic [IDX_W-1:0]            tail_q;
	logic [CNT_W-1:0]            qcnt_q;
	logic [IDX_W-1:0]            x_q;
	logic [MAX_NODES-1:0]        pend_q;
	logic [IDX_W-1:0]            emit_q;
	out_item_t                   out_q;
	logic                        out_valid_q;

	logic [MAX_NODES-1:0] hit_a, hit_b, white_vec, cand;
	logic [IDX_W-1:0]     idx_a, idx_b, nxt, pop_x;
	logic                 full, out_free;
	logic [IDX_W-1:0]     cnt_idx;

	assign cnt_idx = count_q[IDX_W-1:0];

	// parallel key compare against the stored nodes
	always_comb begin
		for (int i = 0; i < MAX_NODES; i++) begin
			hit_a[i]     = (CNT_W'(i) < count_q) && (key_q[i] == req_q.key_a);
			hit_b[i]     = (CNT_W'(i) < count_q) && (key_q[i] == req_q.key_b);
			white_vec[i] = (color_q[i] == COLOR_WHITE);
		end
	end

	assign idx_a    = lowest_idx(hit_a);
	assign idx_b    = lowest_idx(hit_b);
	assign full     = (count_q == CNT_W'(MAX_NODES));
	assign cand     = pend_q & white_vec;
	assign nxt      = lowest_idx(cand);
	assign pop_x    = queue_q[head_q];
	assign out_free = !out_valid_q || !out_stall;

	assign stat.req_type  = req_q.req_type;
	assign stat.src_found = |hit_a;
	assign stat.q_empty   = (qcnt_q == '0);
	assign stat.scan_done = (cand == '0);
	assign stat.emit_last = (CNT_W'(emit_q) + CNT_W'(1) == count_q);
	assign stat.out_free  = out_free;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
			head_q      <= '0;
			tail_q      <= '0;
			qcnt_q      <= '0;
			emit_q      <= '0;
			for (int i = 0; i < MAX_NODES; i++) begin
				row_q[i] <= '0;
			end
		end else begin
			if (cmd.exec || cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.exec) begin
				if (req_q.req_type == REQ_NODE && !full && !(|hit_a)) begin
					row_q[cnt_idx] <= '0;
					count_q        <= count_q + CNT_W'(1);
				end
				if (req_q.req_type == REQ_EDGE && (|hit_a) && (|hit_b)) begin
					row_q[idx_a][idx_b] <= 1'b1;
				end
			end
			if (cmd.init) begin
				head_q <= '0;
				tail_q <= IDX_W'(1);
				qcnt_q <= CNT_W'(1);
				emit_q <= '0;
			end
			if (cmd.pop) begin
				head_q <= (head_q == IDX_W'(MAX_NODES - 1)) ? '0 : head_q + IDX_W'(1);
				qcnt_q <= qcnt_q - CNT_W'(1);
			end
			if (cmd.scan && cand != '0) begin
				tail_q <= (tail_q == IDX_W'(MAX_NODES - 1)) ? '0 : tail_q + IDX_W'(1);
				qcnt_q <= qcnt_q + CNT_W'(1);
			end
			if (cmd.emit) begin
				emit_q <= emit_q + IDX_W'(1);
			end
		end
	end

	// search state and payload storage
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= in_data;
		end
		if (cmd.exec && req_q.req_type == REQ_NODE && !full && !(|hit_a)) begin
			key_q[cnt_idx] <= req_q.key_a;
		end
		if (cmd.exec) begin
			out_q                 <= '0;
			out_q.last            <= 1'b1;
			out_q.node_key        <= req_q.key_a;
			case (req_q.req_type)
				REQ_NODE: begin
					if (full) begin
						out_q.status <= ST_FULL;
					end else if (|hit_a) begin
						out_q.status     <= ST_DUP;
						out_q.node_index <= OUT_IDX_W'(idx_a);
					end else begin
						out_q.status     <= ST_OK;
						out_q.node_index <= OUT_IDX_W'(count_q);
					end
				end
				REQ_EDGE: begin
					out_q.status <= ((|hit_a) && (|hit_b)) ? ST_OK : ST_UNKNOWN;
				end
				default: begin
					out_q.status   <= ST_UNKNOWN;
					out_q.node_key <= '0;
				end
			endcase
		end
		if (cmd.init) begin
			for (int i = 0; i < MAX_NODES; i++) begin
				color_q[i] <= COLOR_WHITE;
			end
			pvalid_q       <= '0;
			color_q[idx_a] <= COLOR_GREY;
			dist_q[idx_a]  <= '0;
			queue_q[0]     <= idx_a;
		end
		if (cmd.pop) begin
			x_q    <= pop_x;
			pend_q <= row_q[pop_x];
		end
		if (cmd.scan) begin
			if (cand != '0) begin
				color_q[nxt]  <= COLOR_GREY;
				queue_q[tail_q] <= nxt;
				parent_q[nxt] <= x_q;
				pvalid_q[nxt] <= 1'b1;
				dist_q[nxt]   <= dist_q[x_q] + OUT_IDX_W'(1);
				pend_q[nxt]   <= 1'b0;
			end else begin
				color_q[x_q] <= COLOR_BLACK;
			end
		end
		if (cmd.emit) begin
			out_q.status          <= ST_OK;
			out_q.node_index      <= OUT_IDX_W'(emit_q);
			out_q.node_key        <= key_q[emit_q];
			out_q.reached         <= (color_q[emit_q] != COLOR_WHITE);
			out_q.distance        <= (color_q[emit_q] != COLOR_WHITE) ? dist_q[emit_q] : '0;
			out_q.has_predecessor <= pvalid_q[emit_q];
			out_q.predecessor     <= pvalid_q[emit_q] ? OUT_IDX_W'(parent_q[emit_q]) : '0;
			out_q.last            <= stat.emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_qcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qcnt_q <= CNT_W'(MAX_NODES)) else $error("work queue overflow");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_NODES)) else $error("node count overflow");
	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (CNT_W'(emit_q) < count_q)) else $error("emit past node count");
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec || cmd.emit) |=> out_valid_q) else $error("result lost");
`endif
endmodule

@@ hw/rtl/bfsam_ctrl.sv @@
// ---------------------------------------------------------------------------
// bfsam_ctrl
// sequencer for request execution, search walk and result emission
// ---------------------------------------------------------------------------
module bfsam_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  bfsam_pkg::stat_t stat,
	output bfsam_pkg::cmd_t  cmd
);
	import bfsam_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (stat.req_type == REQ_NONE) begin
					state_d = S_IDLE;
				end else if (stat.req_type == REQ_SEARCH && stat.src_found) begin
					state_d = S_POP;
				end else if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			S_POP: state_d = S_SCAN;
			S_SCAN: begin
				if (stat.scan_done) state_d = stat.q_empty ? S_EMIT : S_POP;
			end
			S_EMIT: begin
				if (stat.out_free && stat.emit_last) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: cmd.load = in_valid;
			S_EXEC: begin
				if (stat.req_type == REQ_SEARCH && stat.src_found) begin
					cmd.init = 1'b1;
				end else if (stat.req_type != REQ_NONE) begin
					cmd.exec = stat.out_free;
				end
			end
			S_POP:  cmd.pop  = 1'b1;
			S_SCAN: cmd.scan = 1'b1;
			S_EMIT: cmd.emit = stat.out_free;
			default: cmd = '0;
		endcase
	end
endmodule

@@ hw/rtl/bfs_adjacency_matrix_engine.sv @@
// ---------------------------------------------------------------------------
// bfs_adjacency_matrix_engine
// keyed directed graph store with breadth-first search over an adjacency matrix
// ---------------------------------------------------------------------------
// add node / add edge: the request is registered, then its result once the output is free
// search: source queued, nodes popped and scanned, then one result per stored node
//   per cycle while the output is free; one newly found node per scan cycle sets the walk
// one item in flight at a time; the next item is taken after the last result registers
// reset: node count, adjacency matrix, queue pointers and state machine cleared;
//   key table and search marks are undefined until written
module bfs_adjacency_matrix_engine (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  bfsam_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output bfsam_pkg::out_item_t out_data
);
	import bfsam_pkg::*;

	// command and status between sequencer and datapath
	cmd_t  cmd;
	stat_t stat;

	// sequencer: accepts a transaction, walks the search, emits results
	bfsam_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: graph storage, queue, marks and the result register
	bfsam_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);
endmodule

@@ dv/bfs_adjacency_matrix_engine_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// bfs_adjacency_matrix_engine_tb
// drives node, edge and search transactions into the engine, predicts every
// result with a behavioral graph model and compares each output transaction
// ---------------------------------------------------------------------------
module bfs_adjacency_matrix_engine_tb;
	import bfsam_pkg::*;

	localparam int N_RANDOM    = 360;
	localparam int CYCLE_LIMIT = 2000000;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_data;

	bfs_adjacency_matrix_engine uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	// clock, 4 ns period
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor copy of the graph
	logic signed [KEY_W-1:0] graph_keys [MAX_NODES];
	logic [MAX_NODES-1:0]    graph_adj  [MAX_NODES];
	int                      graph_count;

	out_item_t expected_results [$];
	int        n_errors;
	int        cycle_count;

	// idle rates in percent, changed per phase
	int send_idle_pct;
	int recv_idle_pct;

	// directed rows: kind, keys, whether a typed expectation applies
	typedef struct {
		req_kind_t               kind;
		logic signed [KEY_W-1:0] ka;
		logic signed [KEY_W-1:0] kb;
		logic                    typed;
		status_t                 st;
		logic [OUT_IDX_W-1:0]    idx;
	} stim_row_t;

	function automatic int find_key(logic signed [KEY_W-1:0] k);
		for (int i = 0; i < graph_count; i++) begin
			if (graph_keys[i] == k) begin
				return i;
			end
		end
		return -1;
	endfunction

	function automatic out_item_t make_result(status_t st, int idx, logic signed [KEY_W-1:0] k);
		out_item_t r;
		r = '0;
		r.status     = st;
		r.node_index = OUT_IDX_W'(idx);
		r.node_key   = k;
		r.last       = 1'b1;
		return r;
	endfunction

	// predict the results of one transaction and queue them
	task automatic predict_graph_op(in_item_t item);
		int a;
		int b;
		int head;
		int x;
		int qlen;
		logic [1:0] color [MAX_NODES];
		int  hops   [MAX_NODES];
		int  parent [MAX_NODES];
		logic haspar [MAX_NODES];
		int  wq     [MAX_NODES];
		out_item_t r;
		case (item.req_type)
			REQ_NODE: begin
				if (graph_count >= MAX_NODES) begin
					expected_results.push_back(make_result(ST_FULL, 0, item.key_a));
				end else begin
					a = find_key(item.key_a);
					if (a >= 0) begin
						expected_results.push_back(make_result(ST_DUP, a, item.key_a));
					end else begin
						graph_keys[graph_count] = item.key_a;
						graph_adj[graph_count]  = '0;
						expected_results.push_back(make_result(ST_OK, graph_count, item.key_a));
						graph_count++;
					end
				end
			end
			REQ_EDGE: begin
				a = find_key(item.key_a);
				b = find_key(item.key_b);
				if (a < 0 || b < 0) begin
					expected_results.push_back(make_result(ST_UNKNOWN, 0, item.key_a));
				end else begin
					graph_adj[a][b] = 1'b1;
					expected_results.push_back(make_result(ST_OK, 0, item.key_a));
				end
			end
			REQ_SEARCH: begin
				a = find_key(item.key_a);
				if (a < 0) begin
					expected_results.push_back(make_result(ST_UNKNOWN, 0, '0));
				end else begin
					for (int i = 0; i < MAX_NODES; i++) begin
						color[i]  = COLOR_WHITE;
						hops[i]   = 0;
						parent[i] = 0;
						haspar[i] = 1'b0;
					end
					head = 0;
					qlen = 1;
					wq[0] = a;
					color[a] = COLOR_GREY;
					while (head < qlen) begin
						x = wq[head];
						head++;
						for (int i = 0; i < graph_count; i++) begin
							if (graph_adj[x][i] && color[i] == COLOR_WHITE) begin
								color[i]  = COLOR_GREY;
								wq[qlen]  = i;
								qlen++;
								parent[i] = x;
								haspar[i] = 1'b1;
								hops[i]   = (hops[x] + 1) & 63;
							end
						end
						color[x] = COLOR_BLACK;
					end
					for (int i = 0; i < graph_count; i++) begin
						r = make_result(ST_OK, i, graph_keys[i]);
						r.reached         = (color[i] != COLOR_WHITE);
						r.distance        = r.reached ? OUT_IDX_W'(hops[i]) : '0;
						r.has_predecessor = haspar[i];
						r.predecessor     = haspar[i] ? OUT_IDX_W'(parent[i]) : '0;
						r.last            = (i + 1 == graph_count);
						expected_results.push_back(r);
					end
				end
			end
			default: begin
				// undefined request type is dropped
			end
		endcase
	endtask

	task automatic report_mismatch(string what);
		$display("mismatch at cycle %0d: %s", cycle_count, what);
		n_errors++;
	endtask

	// drive one transaction, hold until accepted
	task automatic send_item(in_item_t item);
		logic stalled;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		// stall only moves at the rising edge, so its value at the falling edge holds
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
		predict_graph_op(item);
	endtask

	// receiver stall pattern
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// output checker
	always @(posedge clk) begin
		out_item_t e;
		cycle_count <= cycle_count + 1;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h", out_data));
			end else begin
				e = expected_results.pop_front();
				if (out_data.status !== e.status)
					report_mismatch($sformatf("status %0d want %0d", out_data.status, e.status));
				if (out_data.node_index !== e.node_index)
					report_mismatch($sformatf("node_index %0d want %0d",
						out_data.node_index, e.node_index));
				if (out_data.node_key !== e.node_key)
					report_mismatch($sformatf("node_key %h want %h", out_data.node_key, e.node_key));
				if (out_data.distance !== e.distance)
					report_mismatch($sformatf("distance %0d want %0d",
						out_data.distance, e.distance));
				if (out_data.predecessor !== e.predecessor)
					report_mismatch($sformatf("predecessor %0d want %0d",
						out_data.predecessor, e.predecessor));
				if (out_data.has_predecessor !== e.has_predecessor)
					report_mismatch("has_predecessor");
				if (out_data.reached !== e.reached)
					report_mismatch("reached");
				if (out_data.last !== e.last)
					report_mismatch("last");
			end
		end
	end

	// timeout watchdog
	always @(posedge clk) begin
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// random key: mostly from a small pool so duplicates and hits happen
	function automatic logic signed [KEY_W-1:0] pick_key(int pool);
		int r;
		r = $urandom_range(9);
		if (r == 0) return $urandom();
		if (r == 1) return ($urandom_range(1)) ? 32'sh7fffffff : 32'sh80000000;
		return KEY_W'($urandom_range(pool)) - 32'sd5;
	endfunction

	// random graph session: build nodes, add edges, search a few times
	task automatic run_random_session(int budget);
		in_item_t item;
		int r;
		int pool;
		pool = $urandom_range(1) ? 12 : 40;
		for (int n = 0; n < budget; n++) begin
			r = $urandom_range(99);
			if (r < 30) item.req_type = REQ_NODE;
			else if (r < 80) item.req_type = REQ_EDGE;
			else if (r < 95) item.req_type = REQ_SEARCH;
			else item.req_type = REQ_NONE;
			item.key_a = pick_key(pool);
			item.key_b = pick_key(pool);
			if (graph_count > 0 && $urandom_range(9) < 8) begin
				item.key_a = graph_keys[$urandom_range(graph_count - 1)];
				if ($urandom_range(9) < 8)
					item.key_b = graph_keys[$urandom_range(graph_count - 1)];
			end
			send_item(item);
		end
	endtask

	stim_row_t directed_rows [$];

	initial begin
		in_item_t item;
		out_item_t e;
		int wait_cycles;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_data       = '0;
		out_stall     = 1'b0;
		n_errors      = 0;
		cycle_count   = 0;
		graph_count   = 0;
		send_idle_pct = 11;
		recv_idle_pct = 84;
		for (int i = 0; i < MAX_NODES; i++) begin
			graph_adj[i]  = '0;
			graph_keys[i] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, typed rows are checked against their literal values
		directed_rows = '{
			'{REQ_SEARCH, 32'sd1,          32'sd0,          1'b1, ST_UNKNOWN, 6'd0},
			'{REQ_EDGE,   32'sd1,          32'sd2,          1'b1, ST_UNKNOWN, 6'd0},
			'{REQ_NODE,   32'sh80000000,   32'sd0,          1'b1, ST_OK,      6'd0},
			'{REQ_NODE,   32'sh7fffffff,   32'shffffffff,   1'b1, ST_OK,      6'd1},
			'{REQ_NODE,   32'sd0,          32'sd0,          1'b1, ST_OK,      6'd2},
			'{REQ_NODE,   32'sh80000000,   32'sd0,          1'b1, ST_DUP,     6'd0},
			'{REQ_NONE,   32'shffffffff,   32'shffffffff,   1'b0, ST_OK,      6'd0},
			'{REQ_EDGE,   32'sh80000000,   32'sh7fffffff,   1'b1, ST_OK,      6'd0},
			'{REQ_EDGE,   32'sh80000000,   32'sh7fffffff,   1'b1, ST_OK,      6'd0},
			'{REQ_EDGE,   32'sh7fffffff,   32'sd0,          1'b1, ST_OK,      6'd0},
			'{REQ_EDGE,   32'sd0,          32'sd0,          1'b1, ST_OK,      6'd0},
			'{REQ_EDGE,   32'sd0,          32'sd99,         1'b1, ST_UNKNOWN, 6'd0},
			'{REQ_SEARCH, 32'sh80000000,   32'sd0,          1'b0, ST_OK,      6'd0},
			'{REQ_SEARCH, 32'sd0,          32'sd0,          1'b0, ST_OK,      6'd0}
		};
		for (int k = 0; k < directed_rows.size(); k++) begin
			item.req_type = directed_rows[k].kind;
			item.key_a    = directed_rows[k].ka;
			item.key_b    = directed_rows[k].kb;
			send_item(item);
			if (directed_rows[k].typed) begin
				e = expected_results[$];
				if (e.status !== directed_rows[k].st || e.node_index !== directed_rows[k].idx)
					report_mismatch($sformatf("directed row %0d typed value", k));
			end
		end
		// fill the table to the top; the nodes beyond it give the full case
		for (int k = 0; k < MAX_NODES; k++) begin
			item.req_type = REQ_NODE;
			item.key_a    = 32'sd100 + k;
			item.key_b    = '0;
			send_item(item);
		end
		e = expected_results[$];
		if (e.status !== ST_FULL) report_mismatch("table full row");
		for (int k = 0; k < MAX_NODES - 1; k++) begin
			item.req_type = REQ_EDGE;
			item.key_a    = (k < 3) ? graph_keys[k] : 32'sd100 + k - 3;
			item.key_b    = 32'sd100 + k - 2;
			send_item(item);
		end
		item.req_type = REQ_SEARCH;
		item.key_a    = graph_keys[0];
		send_item(item);

		// random phases on the same graph, each with its own idle rates
		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 1) begin
				send_idle_pct = 84;
				recv_idle_pct = 11;
			end else if (ph == 2) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			run_random_session(N_RANDOM / 3);
		end
		in_valid <= 1'b0;

		// drain, then a short quiet tail
		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
		wait_cycles = 0;
		while (wait_cycles < 100) begin
			@(posedge clk);
			wait_cycles++;
		end
		if (n_errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
